### hdl/nrmc_pkg.sv
// Shared types, constants and a helper function of the RMC fix parser.
`default_nettype none
package nrmc_pkg;

  localparam int LINE_MAX_DEF = 82;
  localparam int AGE_W        = 20;
  localparam int CFG_IDX_W    = 8;
  localparam int OUT_W        = 144;

  localparam logic [AGE_W-1:0]     AGE_RESET       = 20'd30000;
  localparam logic [CFG_IDX_W-1:0] REG_FIX_MAX_AGE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEED_ON     = 8'd1;

  localparam logic [1:0] GPS_OFF    = 2'd0;
  localparam logic [1:0] GPS_NO_FIX = 2'd1;
  localparam logic [1:0] GPS_FIX    = 2'd2;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_BYTE,
    KIND_TICK,
    KIND_EOL
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EX,
    ST_FIN,
    ST_RES
  } back_st_e;

  // Returns {is_hex, value} for one ASCII character.
  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/nrmc_front.sv
// Input side: accepts stream items, classifies them and queues them for the back end.
`default_nettype none
module nrmc_front import nrmc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       in_mode_i,
  input  wire logic [7:0] in_byte_i,
  output queue_t          q_o,
  input  wire logic       q_pop_i
);

  item_t      slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  item_t      cls;
  logic       push;

  always_comb begin
    cls.data = in_byte_i;
    if (in_mode_i) cls.kind = KIND_TICK;
    else if (in_byte_i == CH_CR) cls.kind = KIND_NOP;
    else if (in_byte_i == CH_LF) cls.kind = KIND_EOL;
    else cls.kind = KIND_BYTE;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_o.valid  = (cnt_q != 2'd0);
  assign q_o.item   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule
`default_nettype wire

### hdl/nrmc_back.sv
// Back end: line memory, end-of-line sentence scan, fix state and result register.
`default_nettype none
module nrmc_back import nrmc_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire queue_t           q_i,
  output logic                  q_pop_o,
  input  wire logic [AGE_W-1:0] max_age_i,
  input  wire logic             feed_on_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [OUT_W-1:0]      out_data_o
);

  localparam int AW = $clog2(LINE_MAX);
  localparam int LW = $clog2(LINE_MAX + 1);

  back_st_e state_q, state_d;

  logic [7:0]    line_mem [LINE_MAX];
  logic [7:0]    rdata_q;
  logic [LW-1:0] len_q, p_q;
  logic          ovr_q, fix_q, fwd_q, upd_q;
  logic [AGE_W-1:0] age_q;
  logic [63:0]   lat_q;
  logic [23:0]   deg_q;
  logic [47:0]   tail_q;

  // scan state
  logic [7:0] b0_q, x_q, sum_q, hi_q, lo_q;
  logic       rmc_ok_q, star_q;
  logic [1:0] stg_q;
  logic [2:0] f_q;
  logic [3:0] cnt_q;
  logic       ovf_q, fdone_q;
  logic       st_ok_q, lat_ok_q, ns_ok_q, lon_ok_q, ew_ok_q;
  logic [7:0] st_c_q, ns_c_q, ew_c_q;
  logic [7:0] lat_c_q [7];
  logic [7:0] lon_c_q [8];

  logic       out_vld_q;
  logic [OUT_W-1:0] out_q;

  logic [7:0] c;
  logic       at_end, delim, load;
  logic [3:0] maxlen;
  logic [4:0] hx_hi, hx_lo;
  logic       accepted, ck_ok, is_rmc, pos_ok, valid_now;
  logic [1:0] status_now;

  assign at_end = (p_q == len_q);
  assign c      = at_end ? CH_NUL : rdata_q;
  assign delim  = (c == CH_COMMA) || (c == CH_STAR) || (c == CH_NUL);
  assign maxlen = (f_q == 3'd3 || f_q == 3'd5) ? 4'd15 : 4'd3;
  assign load   = !out_vld_q || out_ready_i;

  assign hx_hi    = hex_dec(hi_q);
  assign hx_lo    = hex_dec(lo_q);
  assign accepted = !ovr_q && (len_q >= LW'(6)) && (b0_q == CH_DOLLAR || b0_q == CH_BANG);
  assign ck_ok    = star_q && hx_hi[4] && hx_lo[4] && ({hx_hi[3:0], hx_lo[3:0]} == sum_q);
  assign is_rmc   = accepted && (len_q >= LW'(7)) && (b0_q == CH_DOLLAR) && rmc_ok_q && ck_ok;
  assign pos_ok   = lat_ok_q && ns_ok_q && lon_ok_q && ew_ok_q;

  assign valid_now  = fix_q && (age_q < max_age_i);
  assign status_now = valid_now ? GPS_FIX : (feed_on_i ? GPS_NO_FIX : GPS_OFF);

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_i.valid) begin
          q_pop_o = 1'b1;
          state_d = (q_i.item.kind == KIND_EOL) ? ST_RD : ST_RES;
        end
      end
      ST_RD:  state_d = ST_EX;
      ST_EX:  state_d = at_end ? ST_FIN : ST_RD;
      ST_FIN: state_d = ST_RES;
      ST_RES: if (load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // Line memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && q_i.valid && q_i.item.kind == KIND_BYTE &&
        len_q < LW'(LINE_MAX))
      line_mem[len_q[AW-1:0]] <= q_i.item.data;
    if (state_q == ST_RD && !at_end) rdata_q <= line_mem[p_q[AW-1:0]];
  end

  // Scan datapath; cleared while the back end is idle.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      p_q <= '0; x_q <= 8'd0; star_q <= 1'b0; stg_q <= 2'd0;
      f_q <= 3'd0; cnt_q <= 4'd0; ovf_q <= 1'b0; fdone_q <= 1'b0;
      st_ok_q <= 1'b0; lat_ok_q <= 1'b0; ns_ok_q <= 1'b0;
      lon_ok_q <= 1'b0; ew_ok_q <= 1'b0; rmc_ok_q <= 1'b1;
    end else if (state_q == ST_EX) begin
      p_q <= p_q + LW'(1);
      if (p_q == LW'(0)) b0_q <= c;
      if ((p_q == LW'(3) && c != CH_R) || (p_q == LW'(4) && c != CH_M) ||
          (p_q == LW'(5) && c != CH_C))
        rmc_ok_q <= 1'b0;
      // Checksum: the last star wins, so each star restarts the capture.
      if (p_q != LW'(0)) begin
        x_q <= x_q ^ c;
        if (c == CH_STAR) begin
          star_q <= 1'b1; sum_q <= x_q; stg_q <= 2'd1; hi_q <= 8'd0; lo_q <= 8'd0;
        end else if (stg_q == 2'd1) begin
          hi_q <= c; stg_q <= 2'd2;
        end else if (stg_q == 2'd2) begin
          lo_q <= c; stg_q <= 2'd3;
        end
      end
      // Field scan stops at the first star or NUL.
      if (!fdone_q) begin
        if (delim) begin
          case (f_q)
            3'd2: st_ok_q  <= !ovf_q && cnt_q != 4'd0 && st_c_q == CH_A;
            3'd3: lat_ok_q <= !ovf_q && cnt_q >= 4'd7 && lat_c_q[4] == CH_DOT;
            3'd4: ns_ok_q  <= !ovf_q && cnt_q == 4'd1;
            3'd5: lon_ok_q <= !ovf_q && cnt_q >= 4'd8 && lon_c_q[5] == CH_DOT;
            3'd6: ew_ok_q  <= !ovf_q && cnt_q == 4'd1;
            default: ;
          endcase
          if (c == CH_COMMA) begin
            if (f_q != 3'd7) f_q <= f_q + 3'd1;
            cnt_q <= 4'd0;
            ovf_q <= 1'b0;
          end else begin
            fdone_q <= 1'b1;
          end
        end else if (!ovf_q) begin
          if (cnt_q >= maxlen) begin
            ovf_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 4'd1;
            if (f_q == 3'd2 && cnt_q == 4'd0) st_c_q <= c;
            if (f_q == 3'd3 && cnt_q < 4'd7) lat_c_q[cnt_q[2:0]] <= c;
            if (f_q == 3'd4 && cnt_q == 4'd0) ns_c_q <= c;
            if (f_q == 3'd5 && cnt_q < 4'd8) lon_c_q[cnt_q[2:0]] <= c;
            if (f_q == 3'd6 && cnt_q == 4'd0) ew_c_q <= c;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovr_q  <= 1'b0;
      fix_q  <= 1'b0;
      age_q  <= '0;
      lat_q  <= 64'd0;
      deg_q  <= 24'd0;
      tail_q <= 48'd0;
      fwd_q  <= 1'b0;
      upd_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (state_q == ST_RES && load) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (q_i.valid) begin
            fwd_q <= 1'b0;
            upd_q <= 1'b0;
            case (q_i.item.kind)
              KIND_TICK: if (age_q != '1) age_q <= age_q + AGE_W'(1);
              KIND_BYTE: begin
                if (len_q < LW'(LINE_MAX)) len_q <= len_q + LW'(1);
                else ovr_q <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_FIN: begin
          fwd_q <= accepted && feed_on_i;
          if (is_rmc) begin
            if (!st_ok_q) begin
              fix_q <= 1'b0;
            end else if (pos_ok) begin
              lat_q  <= {lat_c_q[0], lat_c_q[1], lat_c_q[2], lat_c_q[3],
                         lat_c_q[4], lat_c_q[5], lat_c_q[6], ns_c_q};
              deg_q  <= {lon_c_q[0], lon_c_q[1], lon_c_q[2]};
              tail_q <= {lon_c_q[3], lon_c_q[4], lon_c_q[5], lon_c_q[6],
                         lon_c_q[7], ew_c_q};
              fix_q  <= 1'b1;
              age_q  <= '0;
              upd_q  <= 1'b1;
            end
          end
          len_q <= '0;
          ovr_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RES && load) begin
      out_q <= {3'b000, upd_q, fwd_q,
                valid_now ? tail_q : 48'd0,
                valid_now ? deg_q  : 24'd0,
                valid_now ? lat_q  : 64'd0,
                status_now, valid_now};
    end
  end

endmodule
`default_nettype wire

### hdl/nmea_rmc_fix_parser.sv
// Top level of the NMEA 0183 RMC fix parser: configuration registers, front and back ends.
//
// The block takes serial characters or one-millisecond ticks on the input stream and returns
// exactly one result transfer per input transfer. Characters build a line (CR ignored, LF ends
// it); on LF the stored line is walked once from its first byte, checking the '$' or '!' start,
// the RMC tag, the XOR checksum and the status, latitude and longitude fields, and a good RMC
// sentence stores a new APRS-style fix. A tick or a plain character goes from the queue through
// the result state to the result register; for a line end the line memory is read one byte at
// a time, a read state then a scan state per byte. A two-entry front queue accepts until full
// while the back end scans; the result register holds one result while the back end goes on.
// The user must write configuration only while the block is idle; the block does not check.
`default_nettype none
module nmea_rmc_fix_parser import nrmc_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [7:0]           s_axis_tdata_i,  // [7:0] rx_byte
  input  wire logic [0:0]           s_axis_tuser_i,  // [0] mode: 0 byte, 1 tick
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [0] fix_valid, [2:1] gps_status, [66:3] lat_text, [90:67] lon_deg_text,
  // [138:91] lon_tail_text, [139] line_forward, [140] fix_updated, [143:141] zero
  output logic [OUT_W-1:0]          m_axis_tdata_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [AGE_W-1:0]     cfg_data_i
);

  logic [AGE_W-1:0] max_age_q;
  logic             feed_on_q;
  queue_t           q;
  logic             q_pop;

  // Writes are always taken; an unknown index is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= AGE_RESET;
      feed_on_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FIX_MAX_AGE: max_age_q <= cfg_data_i;
        REG_FEED_ON:     feed_on_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  nrmc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_mode_i  (s_axis_tuser_i[0]),
    .in_byte_i  (s_axis_tdata_i),
    .q_o        (q),
    .q_pop_i    (q_pop)
  );

  nrmc_back #(.LINE_MAX(LINE_MAX)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_i         (q),
    .q_pop_o     (q_pop),
    .max_age_i   (max_age_q),
    .feed_on_i   (feed_on_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

### hdl/nrmc_checker.sv
// Port-level checker of the RMC fix parser and its bind to the top level.
`default_nettype none
module nrmc_checker import nrmc_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             m_axis_tvalid_o,
  input wire logic             m_axis_tready_i,
  input wire logic [OUT_W-1:0] m_axis_tdata_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[2:1] != 2'd3)
    else $error("unused status code");

  a_valid_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[0] == (m_axis_tdata_o[2:1] == GPS_FIX)))
    else $error("fix_valid and status disagree");

  a_no_fix_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[138:3] == '0)
    else $error("position shown without a valid fix");

  a_fwd_feed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[139] |-> m_axis_tdata_o[2:1] != GPS_OFF)
    else $error("line forwarded while status is off");

endmodule

bind nmea_rmc_fix_parser nrmc_checker u_nrmc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
